// ===== rtl/rwb_pkg.sv =====
//------------------------------------------------------------------------------
// rwb_pkg
// Shared types and constants of the rolling window bandwidth block.
//------------------------------------------------------------------------------
package rwb_pkg;

    localparam int MAX_WINDOW_DEF  = 64;
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int RESULT_LIMIT    = 33;

    localparam logic [2:0] CFG_WINDOW_SIZE  = 3'd0;
    localparam logic [2:0] CFG_INTERVAL     = 3'd1;
    localparam logic [2:0] CFG_START        = 3'd2;
    localparam logic [2:0] CFG_COUNT        = 3'd3;
    localparam logic [2:0] CFG_SCALE        = 3'd4;

    typedef struct packed {
        logic [SAMPLE_BITS_DEF-1:0] sample;
        logic                       last_sample;
    } t_in_item;

    typedef struct packed {
        logic [23:0] sigma;
        logic [15:0] window_number;
        logic [6:0]  observations;
        logic        last_of_run;
    } t_out_item;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_RANGE,
        ST_ACC,
        ST_DIFF,
        ST_DIV,
        ST_SQRT,
        ST_MUL1,
        ST_MUL2,
        ST_MUL3,
        ST_EMIT,
        ST_CLEAR
    } t_state;

endpackage

// ===== rtl/rolling_window_bandwidth.sv =====
// Sequence: for a window of n samples, the samples are read from the delay line,
//   then a 64-step divider, a 32-step square root and a binary fifth-root search
//   run one after another; for n <= 1 the divider, root and search are skipped.
// Input: a beat that completes no window frees the input once it is checked; the
//   input is held off until the last result of a run is taken.
// Reset: synchronous, active low; after it and after a last sample the delay line is swept.
//------------------------------------------------------------------------------
// rolling_window_bandwidth
// Centered rolling standard deviation scaled by n^-0.2, over a memory-held
// sample delay line.
//------------------------------------------------------------------------------
module rolling_window_bandwidth #(
    parameter int MAX_WINDOW  = rwb_pkg::MAX_WINDOW_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  rwb_pkg::t_in_item i_data,
    output logic              o_valid,
    input  logic              i_ready,
    output rwb_pkg::t_out_item o_data,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [2:0]        i_cfg_index,
    input  logic [15:0]       i_cfg_data
);
    import rwb_pkg::*;

    localparam int SAMPLE_BITS = SAMPLE_BITS_DEF;
    localparam int AW    = $clog2(MAX_WINDOW);
    localparam int GUARD = (53 - 2 * SAMPLE_BITS) / 2;
    localparam int KSH   = 8 + (SAMPLE_BITS - 1) + GUARD;
    localparam int SW    = 2 * SAMPLE_BITS + 8;      // sum of squares width
    localparam int DW    = 64;                       // divider width

    // configuration
    logic [6:0]  r_wsize;
    logic [12:0] r_interval;
    logic [15:0] r_start, r_wcount, r_scale;

    // stream state
    t_state      r_st, n_st;
    logic [15:0] r_seen, r_emitted;
    logic        r_last;
    logic [5:0]  r_cnt;
    logic [AW:0] r_clr;

    // window working registers
    logic [16:0] r_hi, r_j;
    logic [6:0]  r_n;
    logic signed [SAMPLE_BITS+7:0] r_s;
    logic [SW-1:0] r_q;
    logic        r_rd_v;
    logic [DW-1:0] r_num, r_den, r_quo, r_rem;
    logic [6:0]  r_step;
    logic [31:0] r_root;
    logic [DW-1:0] r_sqv;
    logic [31:0] r_sqr;
    logic [16:0] r_ylo, r_yhi, r_y;
    logic [4:0]  r_ypow;
    logic [95:0] r_yacc;
    logic [63:0] r_prod;
    t_out_item   r_out;
    logic        r_ov;
    logic        r_pend;

    // memory
    logic            ram_we;
    logic [AW-1:0]   ram_wa, ram_ra;
    logic [SAMPLE_BITS-1:0] ram_wd, ram_rd;
    logic signed [2*SAMPLE_BITS-1:0] rd_ext;
    logic [2*SAMPLE_BITS-1:0] rd_sq;

    rwb_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_WINDOW)) u_line (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_wa),
        .i_wdata(ram_wd),
        .i_raddr(ram_ra),
        .o_rdata(ram_rd)
    );

    assign rd_ext = (2*SAMPLE_BITS)'($signed(ram_rd));
    assign rd_sq  = rd_ext * rd_ext;

    // effective geometry
    logic [6:0]  w_eff, left, right;
    logic [12:0] step_eff;
    logic [31:0] center;
    logic [32:0] hi_full;
    logic        accept, ready_win, flush_win, more;

    always_comb begin
        w_eff = (r_wsize == '0) ? 7'd1 :
                (32'(r_wsize) > MAX_WINDOW) ? 7'(MAX_WINDOW) : r_wsize;
        left  = (w_eff - 7'd1) >> 1;
        right = w_eff - left;
        step_eff = (r_interval == '0) ? 13'd1 : r_interval;
        center = 32'(r_start) + 32'(r_emitted) * 32'(step_eff);
        hi_full = 33'(center) + 33'(right);
        ready_win = hi_full <= 33'(r_seen);
        flush_win = r_last && (center < 32'(r_seen));
        more = (r_emitted < r_wcount) && (32'(r_cnt) < RESULT_LIMIT) &&
               (ready_win || flush_win);
    end

    assign o_ready     = (r_st == ST_IDLE) && !r_ov;
    assign o_cfg_ready = (r_st == ST_IDLE) && !r_ov;
    assign accept      = i_valid && o_ready;
    assign o_valid     = r_ov;
    assign o_data      = r_out;

    // fifth-root trial: n * y^5 <= 2^80
    logic [16:0] y_mid;
    assign y_mid = 17'((18'(r_ylo) + 18'(r_yhi) + 18'd1) >> 1);

    always_comb begin
        ram_we = 1'b0;
        ram_wa = r_seen[AW-1:0];
        ram_wd = i_data.sample[SAMPLE_BITS-1:0];
        ram_ra = r_j[AW-1:0];
        if (r_st == ST_CLEAR) begin
            ram_we = 1'b1;
            ram_wa = r_clr[AW-1:0];
            ram_wd = '0;
        end else if (accept && r_seen != 16'hFFFF) begin
            ram_we = 1'b1;
        end
    end

    always_comb begin
        n_st = r_st;
        case (r_st)
            ST_CLEAR: if (r_clr == (AW+1)'(MAX_WINDOW - 1)) n_st = ST_IDLE;
            ST_IDLE:  if (accept) n_st = ST_CHECK;
            ST_CHECK: begin
                if (r_ov || r_pend) n_st = ST_CHECK;
                else if (more) n_st = ST_RANGE;
                else if (r_last) n_st = ST_CLEAR;
                else n_st = ST_IDLE;
            end
            ST_RANGE: n_st = ST_ACC;
            ST_ACC:   if (r_j >= r_hi && !r_rd_v) n_st = ST_DIFF;
            ST_DIFF:  n_st = (r_n <= 7'd1) ? ST_EMIT : ST_DIV;
            ST_DIV:   if (r_step == 7'd64) n_st = ST_SQRT;
            ST_SQRT:  if (r_step == 7'd32) n_st = ST_MUL1;
            ST_MUL1:  if (r_ylo == r_yhi && r_ypow == 5'd0) n_st = ST_MUL2;
            ST_MUL2:  n_st = ST_MUL3;
            ST_MUL3:  n_st = ST_EMIT;
            ST_EMIT:  n_st = ST_CHECK;
            default:  n_st = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_CLEAR;
            r_clr <= '0;
            r_wsize <= 7'd16;
            r_interval <= 13'd1;
            r_start <= '0;
            r_wcount <= 16'd1;
            r_scale <= 16'd256;
            r_seen <= '0;
            r_emitted <= '0;
            r_last <= 1'b0;
            r_cnt <= '0;
            r_ov <= 1'b0;
            r_pend <= 1'b0;
            r_rd_v <= 1'b0;
        end else begin
            r_st <= n_st;
            if (r_ov && i_ready) r_ov <= 1'b0;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_WINDOW_SIZE: r_wsize    <= i_cfg_data[6:0];
                    CFG_INTERVAL:    r_interval <= i_cfg_data[12:0];
                    CFG_START:       r_start    <= i_cfg_data;
                    CFG_COUNT:       r_wcount   <= i_cfg_data;
                    CFG_SCALE:       r_scale    <= i_cfg_data;
                    default: ;
                endcase
            end
            case (r_st)
                ST_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    r_seen <= '0;
                    r_emitted <= '0;
                    r_last <= 1'b0;
                end
                ST_IDLE: begin
                    r_clr <= '0;
                    if (accept) begin
                        if (r_seen != 16'hFFFF) r_seen <= r_seen + 1'b1;
                        r_last <= i_data.last_sample;
                        r_cnt <= '0;
                    end
                end
                ST_CHECK: begin
                    // release the held beat once it is known whether another follows
                    if (!r_ov && r_pend) begin
                        r_out.last_of_run <= !more;
                        r_ov <= 1'b1;
                        r_pend <= 1'b0;
                    end
                end
                ST_RANGE: begin
                    r_hi <= ready_win ? 17'(hi_full) : 17'(r_seen);
                    r_j  <= (center > 32'(left)) ? 17'(center - 32'(left)) : 17'd0;
                    r_s <= '0;
                    r_q <= '0;
                    r_n <= '0;
                    r_rd_v <= 1'b0;
                end
                ST_ACC: begin
                    r_rd_v <= r_j < r_hi;
                    if (r_j < r_hi) r_j <= r_j + 1'b1;
                    if (r_rd_v) begin
                        r_s <= r_s + (SAMPLE_BITS+8)'($signed(ram_rd));
                        r_q <= r_q + SW'(rd_sq);
                        r_n <= r_n + 1'b1;
                    end
                end
                ST_DIFF: begin
                    r_num <= DW'((DW'(r_n) * DW'(r_q) -
                        DW'(r_s < 0 ? -r_s : r_s) * DW'(r_s < 0 ? -r_s : r_s))
                        << (2 * GUARD));
                    r_den <= DW'(r_n) * DW'(r_n - 7'd1);
                    r_rem <= '0;
                    r_step <= '0;
                    r_out.sigma <= '0;
                end
                ST_DIV: begin
                    if (r_step < 7'd64) begin
                        logic [DW:0] t;
                        t = {r_rem, r_num[DW-1]};
                        r_num <= {r_num[DW-2:0], 1'b0};
                        if (t >= {1'b0, r_den}) begin
                            r_rem <= DW'(t - {1'b0, r_den});
                            r_quo <= {r_quo[DW-2:0], 1'b1};
                        end else begin
                            r_rem <= t[DW-1:0];
                            r_quo <= {r_quo[DW-2:0], 1'b0};
                        end
                        r_step <= r_step + 1'b1;
                    end else begin
                        r_sqv <= r_quo;
                        r_sqr <= '0;
                        r_root <= '0;
                        r_step <= '0;
                    end
                end
                ST_SQRT: begin
                    if (r_step < 7'd32) begin
                        logic [33:0] t2, tr;
                        t2 = {r_sqr, r_sqv[DW-1:DW-2]};
                        tr = {r_root, 2'b01};
                        r_sqv <= {r_sqv[DW-3:0], 2'b00};
                        if (t2 >= tr) begin
                            r_sqr <= 32'(t2 - tr);
                            r_root <= {r_root[30:0], 1'b1};
                        end else begin
                            r_sqr <= t2[31:0];
                            r_root <= {r_root[30:0], 1'b0};
                        end
                        r_step <= r_step + 1'b1;
                    end else begin
                        r_ylo <= '0;
                        r_yhi <= 17'd65536;
                        r_ypow <= '0;
                        r_yacc <= 96'(r_n);
                    end
                end
                ST_MUL1: begin
                    // binary search for y; each trial multiplies 5 times
                    if (r_ylo != r_yhi) begin
                        if (r_ypow < 5'd5) begin
                            r_yacc <= 96'(r_yacc * 96'(y_mid));
                            r_ypow <= r_ypow + 1'b1;
                        end else begin
                            if (r_yacc <= (96'd1 << 80)) r_ylo <= y_mid;
                            else r_yhi <= y_mid - 1'b1;
                            r_ypow <= '0;
                            r_yacc <= 96'(r_n);
                        end
                    end else begin
                        r_ypow <= '0;
                        r_y <= r_ylo;
                    end
                end
                ST_MUL2: r_prod <= 64'(r_root) * 64'(r_y);
                ST_MUL3: r_prod <= r_prod * 64'(r_scale);
                ST_EMIT: begin
                    logic [63:0] rt;
                    rt = (r_prod + (64'd1 << (KSH - 1))) >> KSH;
                    if (r_n > 7'd1) r_out.sigma <= (rt > 64'hFFFFFF) ? 24'hFFFFFF : rt[23:0];
                    r_out.window_number <= r_emitted;
                    r_out.observations <= r_n;
                    r_emitted <= r_emitted + 1'b1;
                    r_cnt <= r_cnt + 1'b1;
                    r_pend <= 1'b1;
                end
                default: ;
            endcase
        end
    end
endmodule

// ===== rtl/rwb_ram.sv =====
//------------------------------------------------------------------------------
// rwb_ram
// Generic single-port-write, single-port-read RAM with registered read data.
//------------------------------------------------------------------------------
module rwb_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ===== rtl/rwb_checker.sv =====
//------------------------------------------------------------------------------
// rwb_checker
// Port-level checks of the rolling window bandwidth block.
//------------------------------------------------------------------------------
module rwb_checker (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             o_ready,
    input logic             o_valid,
    input logic             i_ready,
    input rwb_pkg::t_out_item o_data,
    input logic             o_cfg_ready
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data))
        else $error("result beat dropped while stalled");
    a_nosig: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.observations <= 7'd1 |-> o_data.sigma == '0)
        else $error("nonzero sigma for small window");
    a_cfg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cfg_ready |-> o_ready)
        else $error("config open while input blocked");
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready)
        else $error("input taken while result pending");
endmodule

bind rolling_window_bandwidth rwb_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_ready(o_ready),
    .o_valid(o_valid), .i_ready(i_ready), .o_data(o_data),
    .o_cfg_ready(o_cfg_ready)
);

// ===== bench/tb_rolling_window_bandwidth.sv =====
`timescale 1ns / 100ps
//------------------------------------------------------------------------------
// tb_rolling_window_bandwidth
// Streams sample records through the bandwidth block under several register
// settings and random handshake gaps, and checks every result beat against a
// cycle-free predictor of the centered window sigma.
//------------------------------------------------------------------------------
module tb_rolling_window_bandwidth;
    import rwb_pkg::*;

    localparam int          LINE_DEPTH  = 64;
    localparam int          RUN_LIMIT   = 33;
    localparam int          SETTLE      = 400;
    localparam longint      CYCLE_LIMIT = 5000000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    t_in_item    i_data = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    t_out_item   o_data;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index = CFG_WINDOW_SIZE;
    logic [15:0] i_cfg_data = '0;

    rolling_window_bandwidth i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_data      (i_data),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_data      (o_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // register copies
    logic [6:0]  win_size;
    logic [12:0] win_step;
    logic [15:0] first_center;
    logic [15:0] win_total;
    logic [15:0] sigma_scale;

    // stream copies
    int          sample_line [LINE_DEPTH];
    int unsigned samples_seen;
    int unsigned windows_done;

    t_in_item    sample_q[$];
    t_out_item   sigma_q[$];

    int          tx_idle = 0;
    int          rx_idle = 0;
    bit          failed = 1'b0;
    int unsigned results_seen = 0;
    int          hold_left = 0;
    bit          hold_done = 1'b0;
    longint      cycles = 0;

    function automatic int unsigned inv_fifth_root(int unsigned n);
        int unsigned lo;
        int unsigned hi;
        int unsigned mid;
        logic [127:0] prod;
        lo = 0;
        hi = 65536;
        while (lo < hi) begin
            mid = (lo + hi + 1) / 2;
            prod = n;
            repeat (5) prod = prod * mid;
            if (prod <= (128'd1 << 80)) lo = mid;
            else hi = mid - 1;
        end
        return lo;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned res;
        longint unsigned bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic logic [23:0] window_sigma(longint unsigned lo, longint unsigned hi,
                                                 output int unsigned n);
        longint          s;
        longint unsigned q;
        longint unsigned sa;
        longint unsigned d;
        longint unsigned r;
        longint unsigned t;
        int              x;
        s = 0;
        q = 0;
        n = 0;
        for (longint unsigned j = lo; j < hi; j++) begin
            x = sample_line[j % LINE_DEPTH];
            s += x;
            q += longint'(x * x);
            n++;
        end
        if (n <= 1) return '0;
        sa = (s < 0) ? -s : s;
        d = longint'(n) * q - sa * sa;
        r = int_sqrt((d << 20) / (longint'(n) * (n - 1)));
        t = r * inv_fifth_root(n) * longint'(sigma_scale);
        t = (t + (64'd1 << 32)) >> 33;
        return (t > 64'hFFFFFF) ? 24'hFFFFFF : t[23:0];
    endfunction

    task automatic clear_stream();
        foreach (sample_line[k]) sample_line[k] = 0;
        samples_seen = 0;
        windows_done = 0;
    endtask

    // Work out every sigma beat that one accepted sample releases.
    task automatic predict_sample(t_in_item item);
        int unsigned     w;
        int unsigned     left;
        int unsigned     right;
        int unsigned     step;
        int unsigned     count;
        int unsigned     n;
        longint unsigned c;
        longint unsigned hi;
        longint unsigned lo;
        t_out_item       res;
        if (samples_seen < 65535) begin
            sample_line[samples_seen % LINE_DEPTH] = int'($signed(item.sample));
            samples_seen++;
        end
        w = (win_size == 0) ? 1 : win_size;
        if (w > LINE_DEPTH) w = LINE_DEPTH;
        left = (w - 1) / 2;
        right = w - left;
        step = (win_step == 0) ? 1 : win_step;
        count = 0;
        while (count < RUN_LIMIT && windows_done < win_total) begin
            c = longint'(first_center) + longint'(windows_done) * step;
            hi = c + right;
            if (hi > samples_seen) begin
                if (!(item.last_sample && c < samples_seen)) break;
                hi = samples_seen;
            end
            lo = (c > left) ? c - left : 0;
            if (lo < hi) begin
                res.sigma = window_sigma(lo, hi, n);
            end else begin
                res.sigma = '0;
                n = 0;
            end
            res.window_number = windows_done[15:0];
            res.observations = n[6:0];
            res.last_of_run = 1'b0;
            sigma_q.push_back(res);
            windows_done++;
            count++;
        end
        if (count > 0) sigma_q[$].last_of_run = 1'b1;
        if (item.last_sample) clear_stream();
    endtask

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // sample driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || o_ready) begin
            if (i_valid) predict_sample(i_data);
            if (sample_q.size() > 0 && $urandom_range(99) >= tx_idle) begin
                i_valid <= 1'b1;
                i_data <= sample_q.pop_front();
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // result receiver, with one long hold-off to back the block up
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_ready <= 1'b0;
        end else if (!hold_done && results_seen >= 2) begin
            hold_done <= 1'b1;
            hold_left <= 3000;
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= rx_idle);
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_valid && i_ready) begin
            results_seen <= results_seen + 1;
            if (sigma_q.size() == 0) begin
                $error("unexpected result beat: window_number %0d", o_data.window_number);
                failed = 1'b1;
            end else begin
                want = sigma_q.pop_front();
                if (o_data.sigma !== want.sigma) begin
                    $error("sigma: expected %0d, got %0d", want.sigma, o_data.sigma);
                    failed = 1'b1;
                end
                if (o_data.window_number !== want.window_number) begin
                    $error("window_number: expected %0d, got %0d",
                           want.window_number, o_data.window_number);
                    failed = 1'b1;
                end
                if (o_data.observations !== want.observations) begin
                    $error("observations: expected %0d, got %0d",
                           want.observations, o_data.observations);
                    failed = 1'b1;
                end
                if (o_data.last_of_run !== want.last_of_run) begin
                    $error("last_of_run: expected %0d, got %0d",
                           want.last_of_run, o_data.last_of_run);
                    failed = 1'b1;
                end
            end
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [15:0] value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_WINDOW_SIZE: win_size = value[6:0];
            CFG_INTERVAL:    win_step = value[12:0];
            CFG_START:       first_center = value;
            CFG_COUNT:       win_total = value;
            CFG_SCALE:       sigma_scale = value;
            default: ;
        endcase
    endtask

    task automatic set_regs(logic [15:0] w, logic [15:0] st, logic [15:0] c0,
                            logic [15:0] cnt, logic [15:0] sc);
        write_reg(CFG_WINDOW_SIZE, w);
        write_reg(CFG_INTERVAL, st);
        write_reg(CFG_START, c0);
        write_reg(CFG_COUNT, cnt);
        write_reg(CFG_SCALE, sc);
    endtask

    // Let every beat land, then give the block time to finish a silent run.
    task automatic drain();
        while (sample_q.size() > 0 || i_valid || sigma_q.size() > 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic push_sample(int value, bit last);
        t_in_item item;
        item.sample = value[15:0];
        item.last_sample = last;
        sample_q.push_back(item);
    endtask

    task automatic random_regs();
        int pick;
        pick = $urandom_range(9);
        write_reg(CFG_WINDOW_SIZE, pick == 0 ? 16'd0 : pick == 1 ? 16'd127 :
                  pick == 2 ? 16'd64 : 16'($urandom_range(1, 20)));
        pick = $urandom_range(9);
        write_reg(CFG_INTERVAL, pick == 0 ? 16'd0 : 16'($urandom_range(1, 4)));
        write_reg(CFG_START, 16'($urandom_range(0, 12)));
        pick = $urandom_range(9);
        write_reg(CFG_COUNT, pick == 0 ? 16'd65535 : pick == 1 ? 16'd0 :
                  16'($urandom_range(1, 40)));
        write_reg(CFG_SCALE, 16'($urandom));
    endtask

    // Mostly whole records; some stop short and run on into the next.
    task automatic random_records(int total);
        int len;
        while (total > 0) begin
            len = $urandom_range(1, 24);
            if (len > total) len = total;
            for (int k = 0; k < len; k++)
                push_sample(int'($urandom), (k == len - 1) && ($urandom_range(99) >= 15));
            total -= len;
        end
    endtask

    initial begin
        win_size = 7'd16;
        win_step = 13'd1;
        first_center = '0;
        win_total = 16'd1;
        sigma_scale = 16'd256;
        clear_stream();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings, full-scale values, short data flushed at the end
        push_sample(32767, 0);
        push_sample(-32768, 0);
        push_sample(0, 0);
        push_sample(-1, 0);
        push_sample(1, 1);
        drain();

        // saturating sigma, a window at every sample position
        set_regs(16'd2, 16'd1, 16'd0, 16'd65535, 16'd65535);
        push_sample(32767, 0);
        push_sample(-32768, 0);
        push_sample(32767, 0);
        push_sample(-32768, 0);
        push_sample(0, 1);
        drain();

        // centers beyond the data are never emitted
        set_regs(16'd127, 16'd4096, 16'd65535, 16'd1, 16'd0);
        for (int k = 0; k < 4; k++) push_sample(k * 1000 - 2000, k == 3);
        drain();

        // zero window size and interval act as one; single-sample windows
        set_regs(16'd0, 16'd0, 16'd3, 16'd5, 16'd256);
        for (int k = 0; k < 6; k++) push_sample(k * 5000 - 12000, k == 5);
        drain();

        // widen the reach onto overwritten delay-line slots mid-record
        set_regs(16'd8, 16'd1, 16'd0, 16'd0, 16'd300);
        for (int k = 0; k < 66; k++) push_sample(int'($urandom), 0);
        drain();
        write_reg(CFG_COUNT, 16'd3);
        push_sample(-7, 1);
        drain();

        tx_idle = 38;
        rx_idle = 86;
        random_regs();
        random_records(15);
        drain();

        tx_idle = 86;
        rx_idle = 38;
        random_regs();
        random_records(15);
        drain();

        tx_idle = 0;
        rx_idle = 0;
        random_regs();
        random_records(15);
        drain();

        if (!failed) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
